[design/bbs_pkg.sv]
// beep burst sequencer package: shared types and constants
// used by bbs_ctrl, bbs_scale and beep_burst_sequencer
`timescale 1ns / 1ps

package bbs_pkg;

  localparam int unsigned RELOAD_W = 16;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned CMP_W    = 15;
  localparam int unsigned PROD_W   = RELOAD_W + PCT_W;
  localparam int unsigned QUOT_W   = PROD_W - 3;

  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'd35999;
  localparam logic [PCT_W-1:0]    VOL_MAX      = 7'd100;

  // x / 200 = (x >> 3) / 25, the /25 done as a reciprocal multiply
  localparam logic [QUOT_W-1:0]   RECIP_25     = 20'd671089;
  localparam int unsigned         RECIP_SHIFT  = 24;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef struct packed {
    logic             upd;
    logic [PCT_W-1:0] pct;
    logic             busy;
  } ctrl_res_t;

endpackage

[design/bbs_ctrl.sv]
// burst phase state machine: on/off phases, beep count, phase timing
// depends on bbs_pkg
`timescale 1ns / 1ps

module bbs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  command,
  input  logic [31:0]           now_ms,
  input  logic [7:0]            volume_percent,
  input  logic [7:0]            beep_count,
  input  logic [15:0]           on_time_ms,
  input  logic [15:0]           beep_period,
  output bbs_pkg::ctrl_res_t    res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_t;

  phase_t                       phase, phase_next;
  logic [31:0]                  step_start_ms, step_start_ms_next;
  logic [bbs_pkg::PCT_W-1:0]    saved_volume, saved_volume_next;
  logic [7:0]                   beeps_remaining, beeps_remaining_next;
  logic [15:0]                  tone_on_ms, tone_on_ms_next;
  logic [15:0]                  tone_off_ms, tone_off_ms_next;

  logic [31:0]                  elapsed;
  logic [bbs_pkg::PCT_W-1:0]    vol_c;
  logic [15:0]                  on_c;
  logic [7:0]                   beeps_dec;

  assign elapsed   = now_ms - step_start_ms;
  assign vol_c     = (volume_percent > {1'b0, bbs_pkg::VOL_MAX}) ? bbs_pkg::VOL_MAX
                                                                 : volume_percent[6:0];
  assign on_c      = (on_time_ms > beep_period) ? beep_period : on_time_ms;
  assign beeps_dec = beeps_remaining - 8'd1;

  always_comb begin
    phase_next           = phase;
    step_start_ms_next   = step_start_ms;
    saved_volume_next    = saved_volume;
    beeps_remaining_next = beeps_remaining;
    tone_on_ms_next      = tone_on_ms;
    tone_off_ms_next     = tone_off_ms;
    res.upd              = 1'b0;
    res.pct              = '0;
    if (command == bbs_pkg::CMD_START) begin
      if (beep_count != 8'd0) begin
        saved_volume_next    = vol_c;
        beeps_remaining_next = beep_count;
        tone_on_ms_next      = on_c;
        tone_off_ms_next     = beep_period - on_c;
        res.upd              = 1'b1;
        if (vol_c == '0) begin
          phase_next = PH_IDLE;
        end else begin
          res.pct            = vol_c;
          phase_next         = PH_ON;
          step_start_ms_next = now_ms;
        end
      end
    end else begin
      unique case (phase)
        PH_ON: begin
          if (elapsed >= {16'd0, tone_on_ms}) begin
            res.upd              = 1'b1;
            beeps_remaining_next = beeps_dec;
            if (beeps_dec == 8'd0) begin
              phase_next = PH_IDLE;
            end else begin
              phase_next         = PH_OFF;
              step_start_ms_next = now_ms;
            end
          end
        end
        PH_OFF: begin
          if (elapsed >= {16'd0, tone_off_ms}) begin
            res.upd            = 1'b1;
            res.pct            = saved_volume;
            phase_next         = PH_ON;
            step_start_ms_next = now_ms;
          end
        end
        default: begin
        end
      endcase
    end
    res.busy = (phase_next == PH_ON) || (phase_next == PH_OFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      step_start_ms   <= '0;
      saved_volume    <= '0;
      beeps_remaining <= '0;
      tone_on_ms      <= '0;
      tone_off_ms     <= '0;
    end else if (en) begin
      phase           <= phase_next;
      step_start_ms   <= step_start_ms_next;
      saved_volume    <= saved_volume_next;
      beeps_remaining <= beeps_remaining_next;
      tone_on_ms      <= tone_on_ms_next;
      tone_off_ms     <= tone_off_ms_next;
    end
  end

endmodule

[design/bbs_scale.sv]
// compare value scaling: reload * pct registered, then / 200 by reciprocal
// depends on bbs_pkg
`timescale 1ns / 1ps

module bbs_scale (
  input  logic                           clk,
  input  logic                           load_b,
  input  logic                           load_c,
  input  logic [bbs_pkg::RELOAD_W-1:0]   reload,
  input  bbs_pkg::ctrl_res_t             res,
  output logic                           compare_update,
  output logic [bbs_pkg::CMP_W-1:0]      compare_value,
  output logic                           busy_res
);

  logic                                      b_upd;
  logic                                      b_busy;
  logic [bbs_pkg::PROD_W-1:0]                b_prod;
  logic [bbs_pkg::QUOT_W-1:0]                quot8;
  logic [2*bbs_pkg::QUOT_W-1:0]              recip_prod;

  assign quot8      = b_prod[bbs_pkg::PROD_W-1:3];
  assign recip_prod = quot8 * bbs_pkg::RECIP_25;

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_upd  <= res.upd;
      b_busy <= res.busy;
      b_prod <= reload * res.pct;
    end
    if (load_c) begin
      compare_update <= b_upd;
      busy_res       <= b_busy;
      compare_value  <= recip_prod[bbs_pkg::RECIP_SHIFT +: bbs_pkg::CMP_W];
    end
  end

endmodule

[design/beep_burst_sequencer.sv]
// beep burst sequencer top level: stream handshakes, pipeline valids, reload register
// instantiates bbs_ctrl and bbs_scale, depends on bbs_pkg
//
// channel  dir  handshake             payload
// s_axis   in   s_tvalid / s_tready   s_tdata (80b), s_tuser (command)
// m_axis   out  m_tvalid / m_tready   m_tdata (16b), m_tuser (compare_update)
// cfg      in   cfg_valid / cfg_ready cfg_data (tone_reload)
//
// one item per cycle sustained while m_tready stays high; m_tvalid follows the input transfer through the stages below
// stages: input register, state update plus reload*volume product, /200 output register
// sync reset clears stage valids and burst state, and sets reload to 35999
// a stall on the output backs up stage by stage; cfg is always ready
`timescale 1ns / 1ps

module beep_burst_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // now_ms, volume_percent, beep_count, on_time_ms, beep_period
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // compare_value, busy_res
  output logic        m_tuser,   // compare_update
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [bbs_pkg::RELOAD_W-1:0] tone_reload;

  logic        a_v, b_v, c_v;
  logic        a_cmd;
  logic [31:0] a_now;
  logic [7:0]  a_vol;
  logic [7:0]  a_cnt;
  logic [15:0] a_on;
  logic [15:0] a_per;

  logic        a_ready, b_ready, c_ready;
  logic        load_b, load_c;

  bbs_pkg::ctrl_res_t      res;
  logic                    compare_update;
  logic [bbs_pkg::CMP_W-1:0] compare_value;
  logic                    busy_res;

  assign c_ready   = !c_v || m_tready;
  assign load_c    = b_v && c_ready;
  assign b_ready   = !b_v || c_ready;
  assign load_b    = a_v && b_ready;
  assign a_ready   = !a_v || b_ready;
  assign s_tready  = a_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v         <= 1'b0;
      b_v         <= 1'b0;
      c_v         <= 1'b0;
      tone_reload <= bbs_pkg::RELOAD_RESET;
    end else begin
      if (a_ready) begin
        a_v <= s_tvalid;
      end
      if (b_ready) begin
        b_v <= a_v;
      end
      if (c_ready) begin
        c_v <= b_v;
      end
      if (cfg_valid && cfg_ready) begin
        tone_reload <= cfg_data;
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (s_tvalid && a_ready) begin
      a_cmd <= s_tuser;
      a_now <= s_tdata[31:0];
      a_vol <= s_tdata[39:32];
      a_cnt <= s_tdata[47:40];
      a_on  <= s_tdata[63:48];
      a_per <= s_tdata[79:64];
    end
  end

  bbs_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .en             (load_b),
    .command        (a_cmd),
    .now_ms         (a_now),
    .volume_percent (a_vol),
    .beep_count     (a_cnt),
    .on_time_ms     (a_on),
    .beep_period    (a_per),
    .res            (res)
  );

  bbs_scale u_scale (
    .clk            (clk),
    .load_b         (load_b),
    .load_c         (load_c),
    .reload         (tone_reload),
    .res            (res),
    .compare_update (compare_update),
    .compare_value  (compare_value),
    .busy_res       (busy_res)
  );

  assign m_tvalid = c_v;
  assign m_tuser  = compare_update;
  assign m_tdata  = {busy_res, compare_value};

endmodule

[test/tb.sv]
// regression bench for beep_burst_sequencer: directed and random bursts on the input stream,
// every result checked against an in-bench burst predictor, reload changed between phases
// depends on bbs_pkg and the beep_burst_sequencer rtl
`timescale 1ns / 1ps

module tb;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } burst_phase_e;

  typedef struct packed {
    logic        upd;
    logic [14:0] cmp;
    logic        busy;
  } tone_result_t;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // burst predictor state
  burst_phase_e  phase_m = PH_IDLE;
  logic [31:0]   start_ms = '0;
  logic [6:0]    vol_saved = '0;
  logic [7:0]    beeps_left = '0;
  logic [15:0]   on_len = '0;
  logic [15:0]   off_len = '0;
  logic [15:0]   reload_model = bbs_pkg::RELOAD_RESET;

  tone_result_t  pending_tones[$];

  int unsigned   send_gap_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_items = 0;
  int unsigned   results_seen = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   reload_writes = 0;
  int unsigned   cycle_count = 0;
  logic [31:0]   clock_ms = '0;

  beep_burst_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // now_ms, volume_percent, beep_count, on_time_ms, beep_period
    .s_tuser   (s_tuser),   // command
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // compare_value, busy_res
    .m_tuser   (m_tuser),   // compare_update
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [14:0] tone_level(input logic [6:0] pct);
    logic [31:0] prod;
    prod = reload_model * pct;
    return 15'(prod / 200);
  endfunction

  function automatic tone_result_t advance_burst(input logic cmd, input logic [31:0] now,
                                                 input logic [7:0] vol, input logic [7:0] cnt,
                                                 input logic [15:0] on_t,
                                                 input logic [15:0] per);
    tone_result_t r;
    logic [31:0]  elapsed;
    r = '0;
    elapsed = now - start_ms;
    if (cmd == bbs_pkg::CMD_START) begin
      if (cnt != 0) begin
        if (vol > bbs_pkg::VOL_MAX) vol = bbs_pkg::VOL_MAX;
        if (on_t > per) on_t = per;
        vol_saved = vol[6:0];
        beeps_left = cnt;
        on_len = on_t;
        off_len = per - on_t;
        r.upd = 1'b1;
        if (vol == 0) begin
          phase_m = PH_IDLE;
        end else begin
          r.cmp = tone_level(vol[6:0]);
          phase_m = PH_ON;
          start_ms = now;
        end
      end
    end else if (phase_m == PH_ON) begin
      if (elapsed >= on_len) begin
        r.upd = 1'b1;
        beeps_left = beeps_left - 8'd1;
        if (beeps_left == 0) begin
          phase_m = PH_IDLE;
        end else begin
          phase_m = PH_OFF;
          start_ms = now;
        end
      end
    end else if (phase_m == PH_OFF) begin
      if (elapsed >= off_len) begin
        r.upd = 1'b1;
        r.cmp = tone_level(vol_saved);
        phase_m = PH_ON;
        start_ms = now;
      end
    end
    r.busy = (phase_m == PH_ON) || (phase_m == PH_OFF);
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [31:0] now, input logic [7:0] vol,
                           input logic [7:0] cnt, input logic [15:0] on_t,
                           input logic [15:0] per);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {per, on_t, cnt, vol, now};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == bbs_pkg::CMD_START || phase_m != PH_IDLE) burst_items++;
    pending_tones.push_back(advance_burst(cmd, now, vol, cnt, on_t, per));
    items_sent++;
  endtask

  task automatic send_start(input logic [31:0] now, input logic [7:0] vol,
                            input logic [7:0] cnt, input logic [15:0] on_t,
                            input logic [15:0] per);
    send_item(bbs_pkg::CMD_START, now, vol, cnt, on_t, per);
  endtask

  // unused fields of a tick carry junk
  task automatic send_tick(input logic [31:0] now);
    send_item(bbs_pkg::CMD_TICK, now, 8'($urandom), 8'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reload(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reload_model = value;
    reload_writes++;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_tick(32'h0000_1000);
    send_start(32'hFFFF_FFF0, 8'd80, 8'd0, 16'd5, 16'd10);
    send_start(32'hFFFF_FFFF, 8'd255, 8'd1, 16'hFFFF, 16'd0);
    send_tick(32'h0000_0000);
    send_start(32'hFFFF_FFFE, 8'd100, 8'd3, 16'd5, 16'd10);
    send_tick(32'h0000_0002);
    send_tick(32'h0000_0003);
    send_tick(32'h0000_0007);
    send_tick(32'h0000_0008);
    send_start(32'h0000_0009, 8'd60, 8'd0, 16'd1, 16'd2);
    send_tick(32'h0000_000D);
    send_start(32'h8000_0000, 8'd50, 8'd255, 16'hFFFF, 16'hFFFF);
    send_tick(32'h7FFF_FFFF);
    send_tick(32'h7FFF_FFFE);
    send_start(32'h1234_5678, 8'd0, 8'd2, 16'd3, 16'd9);
    send_tick(32'h1234_6000);
    send_start(32'h0000_0000, 8'd1, 8'd1, 16'd0, 16'hFFFF);
    send_tick(32'h0000_0000);
    send_start(32'hFFFF_FFFF, 8'd101, 8'd2, 16'd1, 16'd1);
    send_tick(32'h0000_0000);
    send_tick(32'h0000_0000);
    send_tick(32'h0000_0001);
    wait_drain();
  endtask

  task automatic test_reload_sweep();
    logic [15:0] settings[4];
    settings = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65534))};
    foreach (settings[i]) begin
      write_reload(settings[i]);
      send_start(32'($urandom), 8'd100, 8'd1, 16'd0, 16'd0);
      send_start(32'($urandom), 8'd99, 8'd2, 16'd0, 16'd0);
      send_tick(32'($urandom));
      send_tick(32'($urandom));
      wait_drain();
    end
  endtask

  task automatic test_random_bursts(input int unsigned gap_pct, input int unsigned stall_pct,
                                    input logic [15:0] reload, input int unsigned target);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned ticks;
    logic [7:0]  vol;
    logic [7:0]  cnt;
    logic [15:0] on_t;
    logic [15:0] per;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    write_reload(reload);
    stop_at = burst_items + target;
    while (burst_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_item(1'($urandom), 32'($urandom), 8'($urandom), 8'($urandom),
                  16'($urandom), 16'($urandom));
      end else if (pick < 12) begin
        send_start(32'($urandom), 8'($urandom), 8'd0, 16'($urandom), 16'($urandom));
      end else begin
        pick = $urandom_range(9);
        if (pick == 0) clock_ms = $urandom;
        else if (pick == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(40);
        pick = $urandom_range(99);
        if (pick < 70) vol = 8'($urandom_range(1, 100));
        else if (pick < 85) vol = 8'($urandom_range(101, 255));
        else if (pick < 90) vol = 8'd0;
        else vol = 8'($urandom);
        cnt = ($urandom_range(99) < 80) ? 8'($urandom_range(1, 5)) : 8'($urandom_range(1, 255));
        if ($urandom_range(99) < 85) begin
          per = 16'($urandom_range(0, 20));
          on_t = 16'($urandom_range(0, 24));
        end else begin
          per = 16'($urandom);
          on_t = 16'($urandom);
        end
        send_start(clock_ms, vol, cnt, on_t, per);
        ticks = 0;
        while (phase_m != PH_IDLE && ticks < 60) begin
          pick = $urandom_range(99);
          if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 6);
          else if (pick < 95) clock_ms = clock_ms + $urandom_range(0, 40);
          else clock_ms = clock_ms + $urandom;
          send_tick(clock_ms);
          ticks++;
          if ($urandom_range(199) == 0) break;
        end
        if ($urandom_range(9) == 0) send_tick(clock_ms + $urandom_range(0, 100));
      end
    end
    wait_drain();
  endtask

  always @(posedge clk) begin : check_result
    tone_result_t got;
    tone_result_t want;
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[14:0], m_tdata[15]};
      results_seen++;
      if (pending_tones.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected transfer: update %0b compare %0d busy %0b",
                   got.upd, got.cmp, got.busy);
      end else begin
        want = pending_tones.pop_front();
        if (got.upd !== want.upd || got.cmp !== want.cmp || got.busy !== want.busy) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d mismatch: update %0b/%0b compare %0d/%0d busy %0b/%0b",
                     results_seen, want.upd, got.upd, want.cmp, got.cmp, want.busy, got.busy);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_tones.size());
      $display("beep_burst_sequencer regression: fail");
      $finish;
    end
  end

  initial begin
    send_gap_pct = 6;
    recv_stall_pct = 50;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_reload_sweep();
    test_random_bursts(6, 50, bbs_pkg::RELOAD_RESET, 400);
    test_random_bursts(50, 6, 16'($urandom_range(1, 65535)), 400);
    test_random_bursts(0, 0, 16'hFFFF, 400);
    $display("%0d items sent, %0d burst steps, %0d results checked, %0d reload writes",
             items_sent, burst_items, results_seen, reload_writes);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0 && pending_tones.size() == 0) begin
      $display("beep_burst_sequencer regression: pass");
    end else begin
      $display("beep_burst_sequencer regression: fail");
    end
    $finish;
  end

endmodule
